>>> design/iau_pkg.sv
// Shared types, constants and helpers for the interval arithmetic unit.
// No dependencies; every other design file refers to it by scoped names.
`default_nettype none
package iau_pkg;

  localparam int unsigned W          = 32;
  localparam int unsigned DIV_STEPS  = W;
  localparam int unsigned DIV_LANES  = 4;
  localparam int unsigned IN_TDATA_W = 136;
  localparam int unsigned OUT_TDATA_W = 64;
  localparam int unsigned OUT_TUSER_W = 2;

  localparam logic signed [W-1:0] MAX32 = 32'sh7fff_ffff;
  localparam logic signed [W-1:0] MIN32 = 32'sh8000_0000;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef struct packed {
    op_t                 opcode;
    logic signed [W-1:0] a_low;
    logic signed [W-1:0] a_high;
    logic signed [W-1:0] b_low;
    logic signed [W-1:0] b_high;
  } item_t;

  // One lane of the restoring divider: remainder, dividend bits still to
  // shift in, quotient bits so far, divisor magnitude.
  typedef struct packed {
    logic [W-1:0] r;
    logic [W-1:0] n;
    logic [W-1:0] q;
    logic [W-1:0] d;
  } div_lane_t;

  typedef struct packed {
    logic signed [W-1:0] v;
    logic                sat;
  } clamp_t;

  // Clamp a wide signed value to the 32-bit range and flag clamping.
  function automatic clamp_t clamp64(input logic signed [63:0] x);
    clamp_t c;
    c.sat = 1'b1;
    c.v   = x[W-1:0];
    if (x > 64'(MAX32)) begin
      c.v = MAX32;
    end else if (x < 64'(MIN32)) begin
      c.v = MIN32;
    end else begin
      c.sat = 1'b0;
    end
    return c;
  endfunction

  // Magnitude of a signed word as unsigned (INT_MIN maps to 2^31).
  function automatic logic [W-1:0] mag(input logic signed [W-1:0] x);
    logic [W-1:0] m;
    m = x[W-1] ? W'(-x) : W'(x);
    return m;
  endfunction

endpackage
`default_nettype wire

>>> design/iau_div_step.sv
// One registered restoring-division step: develops one quotient bit.
// Depends on iau_pkg for the lane structure.
`default_nettype none
module iau_div_step (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire iau_pkg::div_lane_t   lane_in,
  output iau_pkg::div_lane_t        lane_out
);

  logic [iau_pkg::W:0]   trial;
  logic                  ge;
  iau_pkg::div_lane_t    lane_next;

  // Trial subtract of the divisor from the shifted partial remainder
  always_comb begin
    trial = {lane_in.r, lane_in.n[iau_pkg::W-1]} - {1'b0, lane_in.d};
    ge    = ~trial[iau_pkg::W];
    lane_next.r = ge ? trial[iau_pkg::W-1:0]
                     : {lane_in.r[iau_pkg::W-2:0], lane_in.n[iau_pkg::W-1]};
    lane_next.n = {lane_in.n[iau_pkg::W-2:0], 1'b0};
    lane_next.q = {lane_in.q[iau_pkg::W-2:0], ge};
    lane_next.d = lane_in.d;
  end

  // Advance the lane when the pipeline moves
  always_ff @(posedge clk) begin
    if (en) begin
      lane_out <= lane_next;
    end
  end

endmodule
`default_nettype wire

>>> design/iau_divider.sv
// Unsigned pipelined divider lane: a chain of one-bit restoring steps.
// Depends on iau_pkg and iau_div_step.
`default_nettype none
module iau_divider (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire iau_pkg::div_lane_t   lane_in,
  output iau_pkg::div_lane_t        lane_out
);

  iau_pkg::div_lane_t chain [iau_pkg::DIV_STEPS+1];

  assign chain[0] = lane_in;

  // Chain the steps, one quotient bit per stage
  for (genvar k = 0; k < iau_pkg::DIV_STEPS; k++) begin : g_step
    iau_div_step u_step (
      .clk      (clk),
      .en       (en),
      .lane_in  (chain[k]),
      .lane_out (chain[k+1])
    );
  end

  assign lane_out = chain[iau_pkg::DIV_STEPS];

endmodule
`default_nettype wire

>>> design/iau_finish.sv
// Final stage: clamps, min/max selection and divide case handling.
// Depends on iau_pkg; feeds the output register in the top level.
`default_nettype none
module iau_finish (
  input  wire iau_pkg::item_t             item,
  input  wire logic signed [63:0]         prod [iau_pkg::DIV_LANES],
  input  wire logic signed [iau_pkg::W:0] quot [iau_pkg::DIV_LANES],
  output logic signed [iau_pkg::W-1:0]    res_low,
  output logic signed [iau_pkg::W-1:0]    res_high,
  output logic                            saturated
);

  iau_pkg::clamp_t c_lo_add, c_hi_add, c_lo_sub, c_hi_sub;
  iau_pkg::clamp_t cp [iau_pkg::DIV_LANES];
  iau_pkg::clamp_t cq [iau_pkg::DIV_LANES];
  logic signed [iau_pkg::W-1:0] pmin, pmax, qmin, qmax;
  logic div_signed, div_zero_bound, div_pos, div_empty;

  // Clamp every candidate bound
  always_comb begin
    c_lo_add = iau_pkg::clamp64(64'(item.a_low) + 64'(item.b_low));
    c_hi_add = iau_pkg::clamp64(64'(item.a_high) + 64'(item.b_high));
    c_lo_sub = iau_pkg::clamp64(64'(item.a_low) - 64'(item.b_high));
    c_hi_sub = iau_pkg::clamp64(64'(item.a_high) - 64'(item.b_low));
    for (int i = 0; i < iau_pkg::DIV_LANES; i++) begin
      cp[i] = iau_pkg::clamp64(prod[i]);
      cq[i] = iau_pkg::clamp64(64'(quot[i]));
    end
  end

  // Min and max of the four corners
  always_comb begin
    pmin = cp[0].v;
    pmax = cp[0].v;
    qmin = cq[0].v;
    qmax = cq[0].v;
    for (int i = 1; i < iau_pkg::DIV_LANES; i++) begin
      if (cp[i].v < pmin) pmin = cp[i].v;
      if (cp[i].v > pmax) pmax = cp[i].v;
      if (cq[i].v < qmin) qmin = cq[i].v;
      if (cq[i].v > qmax) qmax = cq[i].v;
    end
  end

  // Divide case decode
  assign div_signed     = (item.b_low > 0) || (item.b_high < 0);
  assign div_zero_bound = (item.b_low == 0) || (item.b_high == 0);
  assign div_pos        = (item.b_low > 0) && (item.a_low > 0);
  assign div_empty      = (item.b_low == 0) && (item.b_high == 0) &&
                          ((item.a_low > 0) || (item.a_high < 0));

  // Select the result per operation
  always_comb begin
    res_low   = iau_pkg::MIN32;
    res_high  = iau_pkg::MAX32;
    saturated = 1'b0;
    unique case (item.opcode)
      iau_pkg::OP_ADD: begin
        res_low   = c_lo_add.v;
        res_high  = c_hi_add.v;
        saturated = c_lo_add.sat | c_hi_add.sat;
      end
      iau_pkg::OP_SUB: begin
        res_low   = c_lo_sub.v;
        res_high  = c_hi_sub.v;
        saturated = c_lo_sub.sat | c_hi_sub.sat;
      end
      iau_pkg::OP_MUL: begin
        if (item.a_low >= 0 && item.b_low >= 0) begin
          // corners al*bl and ah*bh only
          res_low   = cp[0].v;
          res_high  = cp[3].v;
          saturated = cp[0].sat | cp[3].sat;
        end else begin
          res_low   = pmin;
          res_high  = pmax;
          saturated = cp[0].sat | cp[1].sat | cp[2].sat | cp[3].sat;
        end
      end
      iau_pkg::OP_DIV: begin
        if (div_signed) begin
          if (!div_zero_bound) begin
            saturated = cq[0].sat | cq[1].sat | cq[2].sat | cq[3].sat;
            if (div_pos) begin
              // lanes: 0 al/bl, 1 al/bh, 2 ah/bl, 3 ah/bh
              res_low  = (cq[1].v < cq[3].v) ? cq[1].v : cq[3].v;
              res_high = (cq[0].v > cq[2].v) ? cq[0].v : cq[2].v;
            end else begin
              res_low  = qmin;
              res_high = qmax;
            end
          end
        end else if (div_empty) begin
          res_low  = 32'sd1;
          res_high = 32'sd0;
        end
      end
      default: begin
        res_low = iau_pkg::MIN32;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> design/interval_arithmetic_unit_top.sv
// Pipeline: 1 operand stage, 32 divider stages of one quotient bit each,
// 1 product stage, 1 output register.
// Throughput: one transaction per cycle; the whole pipeline stalls together
// while a finished result waits on m_axis_tready.
// Reset (rst, synchronous, active high) clears all valid bits; no other state.
// Depends on iau_pkg, iau_divider, iau_finish.
`default_nettype none
module interval_arithmetic_unit_top (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // opcode[1:0], a_low[33:2], a_high[65:34], b_low[97:66], b_high[129:98], zeros
  input  wire logic [iau_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // res_low[31:0], res_high[63:32]
  output logic [iau_pkg::OUT_TDATA_W-1:0]          m_axis_tdata,
  // saturated[0], empty_res[1]
  output logic [iau_pkg::OUT_TUSER_W-1:0]          m_axis_tuser
);

  localparam int unsigned META_N = iau_pkg::DIV_STEPS + 1;

  logic                      en;
  iau_pkg::item_t            in_item;
  logic                      meta_valid [META_N];
  iau_pkg::item_t            meta_item  [META_N];
  iau_pkg::div_lane_t        lane_in    [iau_pkg::DIV_LANES];
  iau_pkg::div_lane_t        lane_out   [iau_pkg::DIV_LANES];
  logic                      m_valid;
  iau_pkg::item_t            m_item;
  logic signed [63:0]        prod [iau_pkg::DIV_LANES];
  logic signed [iau_pkg::W:0] quot [iau_pkg::DIV_LANES];
  logic signed [iau_pkg::W-1:0] f_low, f_high;
  logic                      f_sat;
  logic signed [iau_pkg::W-1:0] out_low, out_high;
  logic                      out_sat;
  iau_pkg::op_t              out_op;

  // Advance the whole pipeline unless a result is waiting
  assign en            = ~m_axis_tvalid | m_axis_tready;
  assign s_axis_tready = en;

  assign in_item.opcode = iau_pkg::op_t'(s_axis_tdata[1:0]);
  assign in_item.a_low  = s_axis_tdata[33:2];
  assign in_item.a_high = s_axis_tdata[65:34];
  assign in_item.b_low  = s_axis_tdata[97:66];
  assign in_item.b_high = s_axis_tdata[129:98];

  // Operand stage and operand line alongside the divider
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < META_N; k++) meta_valid[k] <= 1'b0;
    end else if (en) begin
      meta_valid[0] <= s_axis_tvalid;
      for (int k = 1; k < META_N; k++) meta_valid[k] <= meta_valid[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      meta_item[0] <= in_item;
      for (int k = 1; k < META_N; k++) meta_item[k] <= meta_item[k-1];
      lane_in[0] <= '{r: '0, n: iau_pkg::mag(in_item.a_low),
                      q: '0, d: iau_pkg::mag(in_item.b_low)};
      lane_in[1] <= '{r: '0, n: iau_pkg::mag(in_item.a_low),
                      q: '0, d: iau_pkg::mag(in_item.b_high)};
      lane_in[2] <= '{r: '0, n: iau_pkg::mag(in_item.a_high),
                      q: '0, d: iau_pkg::mag(in_item.b_low)};
      lane_in[3] <= '{r: '0, n: iau_pkg::mag(in_item.a_high),
                      q: '0, d: iau_pkg::mag(in_item.b_high)};
    end
  end

  // Four corner dividers: al/bl, al/bh, ah/bl, ah/bh
  for (genvar i = 0; i < iau_pkg::DIV_LANES; i++) begin : g_div
    iau_divider u_div (
      .clk      (clk),
      .en       (en),
      .lane_in  (lane_in[i]),
      .lane_out (lane_out[i])
    );
  end

  // Product stage: corner products and signed quotients
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (en) begin
      m_valid <= meta_valid[META_N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_item  <= meta_item[META_N-1];
      prod[0] <= 64'(meta_item[META_N-1].a_low)  * 64'(meta_item[META_N-1].b_low);
      prod[1] <= 64'(meta_item[META_N-1].a_low)  * 64'(meta_item[META_N-1].b_high);
      prod[2] <= 64'(meta_item[META_N-1].a_high) * 64'(meta_item[META_N-1].b_low);
      prod[3] <= 64'(meta_item[META_N-1].a_high) * 64'(meta_item[META_N-1].b_high);
      quot[0] <= (meta_item[META_N-1].a_low[31] ^ meta_item[META_N-1].b_low[31])
                 ? -$signed({1'b0, lane_out[0].q}) : $signed({1'b0, lane_out[0].q});
      quot[1] <= (meta_item[META_N-1].a_low[31] ^ meta_item[META_N-1].b_high[31])
                 ? -$signed({1'b0, lane_out[1].q}) : $signed({1'b0, lane_out[1].q});
      quot[2] <= (meta_item[META_N-1].a_high[31] ^ meta_item[META_N-1].b_low[31])
                 ? -$signed({1'b0, lane_out[2].q}) : $signed({1'b0, lane_out[2].q});
      quot[3] <= (meta_item[META_N-1].a_high[31] ^ meta_item[META_N-1].b_high[31])
                 ? -$signed({1'b0, lane_out[3].q}) : $signed({1'b0, lane_out[3].q});
    end
  end

  iau_finish u_finish (
    .item      (m_item),
    .prod      (prod),
    .quot      (quot),
    .res_low   (f_low),
    .res_high  (f_high),
    .saturated (f_sat)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_low  <= f_low;
      out_high <= f_high;
      out_sat  <= f_sat;
      out_op   <= m_item.opcode;
    end
  end

  assign m_axis_tdata = {out_high, out_low};
  assign m_axis_tuser = {(out_high < out_low), out_sat};

`ifndef SYNTHESIS
  // A waiting result holds still until it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output changed while stalled");

  // A valid item that leaves the divider while the pipeline moves enters the product stage
  a_valid_flow: assert property (@(posedge clk) disable iff (rst)
    en && meta_valid[META_N-1] |=> m_valid)
    else $error("item lost between divider and product stage");

  // For an unsaturated add result, the empty flag implies the bounds are out of order
  a_addsub_order: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (out_op == iau_pkg::OP_ADD) && !out_sat |->
      !m_axis_tuser[1] || (out_high < out_low))
    else $error("empty flag disagrees with bounds");

  // Reset empties the output register
  a_reset_out: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");
`endif

endmodule
`default_nettype wire

>>> tb/interval_arithmetic_unit_top_tb.sv
// Self-checking testbench for interval_arithmetic_unit_top: directed table plus random
// interval pairs, checked against the table or behavioral predictor. Depends on iau_pkg.
module interval_arithmetic_unit_top_tb;

  typedef struct packed {
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic               sat;
    logic               emp;
  } bounds_t;

  typedef struct {
    iau_pkg::op_t       op;
    logic signed [31:0] al, ah, bl, bh;
    logic               known;
    bounds_t            res;
  } row_t;

  localparam int N_RANDOM = 900;
  localparam logic signed [63:0] HI64 = 64'sd2147483647;
  localparam logic signed [63:0] LO64 = -64'sd2147483648;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [iau_pkg::IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [iau_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic [iau_pkg::OUT_TUSER_W-1:0] m_axis_tuser;

  bounds_t pending_q[$];
  int errors = 0;
  bit stim_done = 1'b0;
  bit hold_sink = 1'b0;

  interval_arithmetic_unit_top u_top (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Clamp a wide value to 32 bits and note clamping.
  function automatic logic signed [63:0] sat32(input logic signed [63:0] v, inout logic s);
    if (v > HI64) begin s = 1'b1; return HI64; end
    if (v < LO64) begin s = 1'b1; return LO64; end
    return v;
  endfunction

  function automatic logic signed [63:0] min4(input logic signed [63:0] p, q, r, t);
    logic signed [63:0] m;
    m = p;
    if (q < m) m = q;
    if (r < m) m = r;
    if (t < m) m = t;
    return m;
  endfunction

  function automatic logic signed [63:0] max4(input logic signed [63:0] p, q, r, t);
    logic signed [63:0] m;
    m = p;
    if (q > m) m = q;
    if (r > m) m = r;
    if (t > m) m = t;
    return m;
  endfunction

  // Compute the expected interval for one operation.
  function automatic bounds_t interval_result(input iau_pkg::op_t op,
                                              input logic signed [31:0] a0, a1, b0, b1);
    logic signed [63:0] al, ah, bl, bh, lo, hi, p0, p1, p2, p3;
    logic s;
    bounds_t r;
    al = a0; ah = a1; bl = b0; bh = b1; s = 1'b0;
    case (op)
      iau_pkg::OP_ADD: begin
        lo = sat32(al + bl, s);
        hi = sat32(ah + bh, s);
      end
      iau_pkg::OP_SUB: begin
        lo = sat32(al - bh, s);
        hi = sat32(ah - bl, s);
      end
      iau_pkg::OP_MUL: begin
        if (al >= 0 && bl >= 0) begin
          lo = sat32(al * bl, s);
          hi = sat32(ah * bh, s);
        end else begin
          p0 = sat32(al * bl, s);
          p1 = sat32(al * bh, s);
          p2 = sat32(ah * bl, s);
          p3 = sat32(ah * bh, s);
          lo = min4(p0, p1, p2, p3);
          hi = max4(p0, p1, p2, p3);
        end
      end
      default: begin
        if (bl > 0 || bh < 0) begin
          if (bl == 0 || bh == 0) begin
            lo = LO64; hi = HI64;
          end else if (bl > 0 && al > 0) begin
            p0 = sat32(al / bh, s);
            p1 = sat32(ah / bh, s);
            p2 = sat32(al / bl, s);
            p3 = sat32(ah / bl, s);
            lo = (p0 < p1) ? p0 : p1;
            hi = (p2 > p3) ? p2 : p3;
          end else begin
            p0 = sat32(al / bl, s);
            p1 = sat32(al / bh, s);
            p2 = sat32(ah / bl, s);
            p3 = sat32(ah / bh, s);
            lo = min4(p0, p1, p2, p3);
            hi = max4(p0, p1, p2, p3);
          end
        end else if (bl == 0 && bh == 0 && (al > 0 || ah < 0)) begin
          lo = 1; hi = 0;
        end else begin
          lo = LO64; hi = HI64;
        end
      end
    endcase
    r.lo = lo[31:0];
    r.hi = hi[31:0];
    r.sat = s;
    r.emp = (hi < lo);
    return r;
  endfunction

  function automatic logic signed [31:0] rand_bound();
    case ($urandom_range(0, 5))
      0: return iau_pkg::MAX32 - 32'($urandom_range(0, 3));
      1: return iau_pkg::MIN32 + 32'($urandom_range(0, 3));
      2: return 32'($urandom_range(0, 8)) - 32'sd4;
      3: return 32'($urandom_range(0, 200000)) - 32'sd100000;
      default: return $urandom;
    endcase
  endfunction

  function automatic row_t mk(input iau_pkg::op_t op, input logic signed [31:0] al, ah, bl, bh,
                              input logic known = 1'b0,
                              input logic signed [31:0] lo = 0, hi = 0,
                              input logic s = 0, e = 0);
    row_t t;
    t.op = op; t.al = al; t.ah = ah; t.bl = bl; t.bh = bh;
    t.known = known; t.res = '{lo, hi, s, e};
    return t;
  endfunction

  // Wait for one input transaction to be accepted, then queue its expectation.
  task automatic send_item(input row_t t);
    bounds_t e;
    s_axis_tdata  <= {6'b0, t.bh, t.bl, t.ah, t.al, t.op};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    e = t.known ? t.res : interval_result(t.op, t.al, t.ah, t.bl, t.bh);
    pending_q = {pending_q, e};
  endtask

  // Insert a random gap after a burst.
  task automatic maybe_gap(inout int burst);
    int g;
    if (burst > 0) begin burst--; return; end
    burst = $urandom_range(0, 30);
    g = $urandom_range(0, 6);
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Directed rows, then random traffic.
  initial begin
    row_t dir[$];
    row_t t;
    int burst;
    burst = 0;
    dir = {dir, mk(iau_pkg::OP_ADD, 1, 2, 3, 4, 1, 4, 6, 0, 0)};
    dir = {dir, mk(iau_pkg::OP_ADD, iau_pkg::MAX32, iau_pkg::MAX32, 1, 1,
                   1, iau_pkg::MAX32, iau_pkg::MAX32, 1, 0)};
    dir = {dir, mk(iau_pkg::OP_ADD, iau_pkg::MIN32, iau_pkg::MIN32, -1, -1,
                   1, iau_pkg::MIN32, iau_pkg::MIN32, 1, 0)};
    dir = {dir, mk(iau_pkg::OP_SUB, iau_pkg::MIN32, iau_pkg::MAX32, -1, 1,
                   1, iau_pkg::MIN32, iau_pkg::MAX32, 1, 0)};
    dir = {dir, mk(iau_pkg::OP_SUB, 10, 5, 0, 0, 1, 10, 5, 0, 1)};
    dir = {dir, mk(iau_pkg::OP_MUL, 3, 5, 2, 4)};
    dir = {dir, mk(iau_pkg::OP_MUL, iau_pkg::MIN32, iau_pkg::MIN32, iau_pkg::MIN32,
                   iau_pkg::MIN32, 1, iau_pkg::MAX32, iau_pkg::MAX32, 1, 0)};
    dir = {dir, mk(iau_pkg::OP_MUL, iau_pkg::MAX32, iau_pkg::MAX32, iau_pkg::MAX32,
                   iau_pkg::MAX32, 1, iau_pkg::MAX32, iau_pkg::MAX32, 1, 0)};
    dir = {dir, mk(iau_pkg::OP_MUL, -7, 9, -3, 4)};
    dir = {dir, mk(iau_pkg::OP_MUL, 5, 1, 6, 2)};
    dir = {dir, mk(iau_pkg::OP_MUL, iau_pkg::MIN32, iau_pkg::MAX32, -1, 1)};
    dir = {dir, mk(iau_pkg::OP_DIV, 100, 200, 3, 7)};
    dir = {dir, mk(iau_pkg::OP_DIV, -100, 50, -7, -3)};
    dir = {dir, mk(iau_pkg::OP_DIV, -100, -50, -7, -3)};
    dir = {dir, mk(iau_pkg::OP_DIV, iau_pkg::MIN32, iau_pkg::MIN32, -1, -1,
                   1, iau_pkg::MAX32, iau_pkg::MAX32, 1, 0)};
    dir = {dir, mk(iau_pkg::OP_DIV, 1, 2, 0, -5, 1, iau_pkg::MIN32, iau_pkg::MAX32, 0, 0)};
    dir = {dir, mk(iau_pkg::OP_DIV, 1, 2, 5, 0, 1, iau_pkg::MIN32, iau_pkg::MAX32, 0, 0)};
    dir = {dir, mk(iau_pkg::OP_DIV, 3, 9, 0, 0, 1, 1, 0, 0, 1)};
    dir = {dir, mk(iau_pkg::OP_DIV, -9, -3, 0, 0, 1, 1, 0, 0, 1)};
    dir = {dir, mk(iau_pkg::OP_DIV, -1, 1, 0, 0, 1, iau_pkg::MIN32, iau_pkg::MAX32, 0, 0)};
    dir = {dir, mk(iau_pkg::OP_DIV, 4, 8, -2, 3, 1, iau_pkg::MIN32, iau_pkg::MAX32, 0, 0)};
    dir = {dir, mk(iau_pkg::OP_DIV, iau_pkg::MAX32, iau_pkg::MIN32, iau_pkg::MIN32,
                   iau_pkg::MAX32)};
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (dir[i]) send_item(dir[i]);
    for (int n = 0; n < N_RANDOM; n++) begin
      maybe_gap(burst);
      // Let the pipeline drain once, midway.
      if (n == N_RANDOM / 2) begin
        s_axis_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk);
      end
      if (n == N_RANDOM / 4) hold_sink <= 1'b1;
      if (n == N_RANDOM / 4 + 120) hold_sink <= 1'b0;
      t = mk(iau_pkg::op_t'($urandom_range(0, 3)), rand_bound(), rand_bound(),
             rand_bound(), rand_bound());
      if ($urandom_range(0, 3) != 0) begin
        // Mostly proper intervals.
        if (t.ah < t.al) begin t.ah = t.al; t.al = rand_bound(); end
        if (t.ah < t.al) t.ah = t.al;
        if (t.bh < t.bl) t.bh = t.bl;
      end
      send_item(t);
    end
    s_axis_tvalid <= 1'b0;
    stim_done <= 1'b1;
  end

  // Receiver: random stall pattern plus forced hold-offs while hold_sink is set.
  initial begin
    int cnt;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_sink) begin
        m_axis_tready <= 1'b0;
        for (cnt = 0; cnt < 100; cnt++) @(posedge clk);
      end
      m_axis_tready <= ($urandom_range(0, 9) < 7) || (cnt % 64 < 16);
      cnt++;
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    bounds_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h %h", $time, m_axis_tdata, m_axis_tuser);
      end else begin
        e = pending_q.pop_front();
        if (m_axis_tdata[31:0] !== e.lo) begin
          errors++;
          $display("%0t: res_low exp %0d got %0d", $time, e.lo, $signed(m_axis_tdata[31:0]));
        end
        if (m_axis_tdata[63:32] !== e.hi) begin
          errors++;
          $display("%0t: res_high exp %0d got %0d", $time, e.hi,
                   $signed(m_axis_tdata[63:32]));
        end
        if (m_axis_tuser[0] !== e.sat) begin
          errors++;
          $display("%0t: saturated exp %b got %b", $time, e.sat, m_axis_tuser[0]);
        end
        if (m_axis_tuser[1] !== e.emp) begin
          errors++;
          $display("%0t: empty_res exp %b got %b", $time, e.emp, m_axis_tuser[1]);
        end
      end
    end
  end

  // Drain, let the latency pass, then report.
  initial begin
    wait (stim_done);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

>>> sim.f
design/iau_pkg.sv
design/iau_div_step.sv
design/iau_divider.sv
design/iau_finish.sv
design/interval_arithmetic_unit_top.sv
tb/interval_arithmetic_unit_top_tb.sv
